[src/polygon_area_perimeter_center_3d_unit_macros.svh]
// assertion macros shared by the polygon area, perimeter and centre unit
// expects clk_i and rst_ni in the scope of each use
`ifndef POLYGON_AREA_PERIMETER_CENTER_3D_UNIT_MACROS_SVH
`define POLYGON_AREA_PERIMETER_CENTER_3D_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PAPC3D_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition never holds
`define PAPC3D_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

[src/papc3d_pkg.sv]
// types and constants for the polygon area, perimeter and centre unit
// no dependencies
package papc3d_pkg;

  localparam int unsigned MaxVerticesDef = 256;
  localparam int unsigned MinVertices    = 3;
  localparam int unsigned CoordW  = 20;
  localparam int unsigned CntW    = 13;   // holds a vertex count up to 8191
  localparam int unsigned VertW   = 3 * CoordW;
  localparam int unsigned DiffW   = CoordW + 1;
  localparam int unsigned MulW    = 22;
  localparam int unsigned ProdW   = 2 * MulW;
  localparam int unsigned CrossW  = 42;
  localparam int unsigned SplitW  = 21;
  localparam int unsigned HiShift = 2 * SplitW;
  localparam int unsigned MidShift = SplitW + 1;
  localparam int unsigned RadW    = 84;
  localparam int unsigned RootW   = RadW / 2;
  localparam int unsigned SumW    = CoordW + CntW;
  localparam int unsigned MagW    = SumW - 1;
  localparam int unsigned PerimW  = 32;
  localparam int unsigned AreaW   = 56;

  typedef struct packed {
    logic signed [CoordW-1:0] vx;
    logic signed [CoordW-1:0] vy;
    logic signed [CoordW-1:0] vz;
    logic                     final_vertex;
  } vertex_t;

  typedef struct packed {
    logic signed [CoordW-1:0] center_x;
    logic signed [CoordW-1:0] center_y;
    logic signed [CoordW-1:0] center_z;
    logic [PerimW-1:0]        perimeter;
    logic [AreaW-1:0]         area;
    logic                     degenerate;
    logic                     overflow;
  } result_t;

  typedef struct packed {
    logic [CntW-1:0] count;
    logic            dropped;
    logic            bank;
  } job_t;

  typedef enum logic [3:0] {
    BS_IDLE, BS_RDPV, BS_RDV, BS_PMUL, BS_PACC, BS_CMUL, BS_CACC,
    BS_SMUL, BS_SACC, BS_SQRT, BS_DIV, BS_OUT
  } back_state_e;

endpackage

[src/polygon_area_perimeter_center_3d_unit.sv]
// top level of the polygon area, perimeter and centre unit
// depends on papc3d_pkg, papc3d_ram, papc3d_front, papc3d_fifo, papc3d_back
// input channel: one vertex per transfer (in_valid_i, in_stall_o, in_data_i),
//   coordinates in signed q10.10; final_vertex closes the polygon
// output channel: one result per closed polygon (out_valid_o, out_stall_i,
//   out_data_o): centre, perimeter, area and the degenerate/overflow flags
// vertices load at one per cycle into one of two ram banks, so a new polygon
//   loads while the previous one is worked on; input stalls only while both
//   banks hold polygons that are queued or in work
// the compute side reads the last vertex first, then each vertex once in order:
//   per vertex the edge length (three squares, 42-step bit-serial root, then an
//   add) and per fan triangle the area (six products for the cross product, nine
//   partial squares, root), then a 32-step divider for the centre; all products
//   go through the single shared multiplier, and the root gives one bit per cycle
// fewer than three vertices skip the ram walk and go from the job queue straight to the output state
// reset clears the count, the flags, the job queue and the output valid;
//   the ram holds no reset value and needs no clearing
// a stalled result stays in the output register; the compute side waits for
//   it to go before it loads the next one, while loading carries on
`include "polygon_area_perimeter_center_3d_unit_macros.svh"

module polygon_area_perimeter_center_3d_unit #(
  parameter int unsigned MAX_VERTICES = papc3d_pkg::MaxVerticesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  papc3d_pkg::vertex_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output papc3d_pkg::result_t out_data_o
);
  import papc3d_pkg::*;

  localparam int unsigned AddrBits = $clog2(MAX_VERTICES);
  localparam int unsigned RamDepth = 2 << AddrBits;   // one bank per polygon in flight

  logic                wr_en, rd_en;
  logic [AddrBits:0]   wr_addr, rd_addr;
  logic [VertW-1:0]    wr_data, rd_data;
  logic                job_push, job_pop, fifo_empty, fifo_full;
  logic                job_release, back_busy;
  job_t                job_in, job_out;

  papc3d_ram #(
    .WIDTH (VertW),
    .DEPTH (RamDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // loading side
  papc3d_front #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .push_o     (job_push),
    .job_o      (job_in),
    .release_i  (job_release)
  );

  // closed polygons wait here for the compute side
  papc3d_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job_in),
    .pop_i   (job_pop),
    .job_o   (job_out),
    .empty_o (fifo_empty),
    .full_o  (fifo_full)
  );

  // compute side
  papc3d_back #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!fifo_empty),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .release_o   (job_release),
    .busy_o      (back_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  `PAPC3D_ASSERT_NEVER(a_no_push_full, job_push && fifo_full, "job pushed into a full queue")
  `PAPC3D_ASSERT_IMP(a_stall_has_work, in_stall_o, !fifo_empty || back_busy,
                     "input stalled with no polygon queued or in work")
  `PAPC3D_ASSERT_IMP(a_degenerate_zero, out_valid_o && out_data_o.degenerate,
                     out_data_o.perimeter == '0 && out_data_o.area == '0,
                     "degenerate result with non-zero lengths")
endmodule

[src/papc3d_ram.sv]
// generic single write, single read ram with registered read data
// no dependencies beyond the package defaults
module papc3d_ram #(
  parameter int unsigned WIDTH = papc3d_pkg::VertW,
  parameter int unsigned DEPTH = 2 * papc3d_pkg::MaxVerticesDef
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

[src/papc3d_front.sv]
// loading side: stores vertices into one ram bank and hands finished polygons on
// depends on papc3d_pkg
module papc3d_front #(
  parameter int unsigned MAX_VERTICES = papc3d_pkg::MaxVerticesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  papc3d_pkg::vertex_t           in_data_i,
  output logic                          wr_en_o,
  output logic [$clog2(MAX_VERTICES):0] wr_addr_o,
  output logic [papc3d_pkg::VertW-1:0]  wr_data_o,
  output logic                          push_o,
  output papc3d_pkg::job_t              job_o,
  input  logic                          release_i
);
  import papc3d_pkg::*;

  localparam int unsigned CntBits  = $clog2(MAX_VERTICES + 1);
  localparam int unsigned AddrBits = $clog2(MAX_VERTICES);

  logic [CntBits-1:0] cnt_q, cnt_d, cnt_inc;
  logic               drop_q, drop_d;
  logic               bank_q, bank_d;
  logic [1:0]         outst_q, outst_d;
  logic               accept, room;

  // both banks taken: one polygon queued or in work, another waiting
  assign in_stall_o = (outst_q == 2'd2);
  assign accept     = in_valid_i && !in_stall_o;
  assign room       = (cnt_q < CntBits'(MAX_VERTICES));
  assign cnt_inc    = room ? cnt_q + CntBits'(1) : cnt_q;

  assign wr_en_o   = accept && room;
  assign wr_addr_o = {bank_q, cnt_q[AddrBits-1:0]};
  assign wr_data_o = {in_data_i.vx, in_data_i.vy, in_data_i.vz};

  assign push_o        = accept && in_data_i.final_vertex;
  assign job_o.count   = CntW'(cnt_inc);
  assign job_o.dropped = drop_q || !room;
  assign job_o.bank    = bank_q;

  always_comb begin
    cnt_d  = cnt_q;
    drop_d = drop_q;
    bank_d = bank_q;
    if (accept) begin
      if (in_data_i.final_vertex) begin
        cnt_d  = '0;
        drop_d = 1'b0;
        bank_d = !bank_q;
      end else begin
        cnt_d  = cnt_inc;
        drop_d = drop_q || !room;
      end
    end
    outst_d = outst_q + {1'b0, push_o} - {1'b0, release_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      drop_q  <= 1'b0;
      bank_q  <= 1'b0;
      outst_q <= '0;
    end else begin
      cnt_q   <= cnt_d;
      drop_q  <= drop_d;
      bank_q  <= bank_d;
      outst_q <= outst_d;
    end
  end
endmodule

[src/papc3d_fifo.sv]
// two-entry job queue between the loading side and the compute side
// depends on papc3d_pkg
module papc3d_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  papc3d_pkg::job_t job_i,
  input  logic             pop_i,
  output papc3d_pkg::job_t job_o,
  output logic             empty_o,
  output logic             full_o
);
  import papc3d_pkg::*;

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign job_o   = mem_q[rd_q];
  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
endmodule

[src/papc3d_back.sv]
// compute side: walks one stored polygon for sums, edge lengths and fan triangle areas, then the centre
// depends on papc3d_pkg; one shared multiplier and bit-serial root, and a bit-serial divider per coordinate
module papc3d_back #(
  parameter int unsigned MAX_VERTICES = papc3d_pkg::MaxVerticesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          job_valid_i,
  input  papc3d_pkg::job_t              job_i,
  output logic                          job_pop_o,
  output logic                          rd_en_o,
  output logic [$clog2(MAX_VERTICES):0] rd_addr_o,
  input  logic [papc3d_pkg::VertW-1:0]  rd_data_i,
  output logic                          release_o,
  output logic                          busy_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output papc3d_pkg::result_t           out_data_o
);
  import papc3d_pkg::*;

  localparam int unsigned AddrBits = $clog2(MAX_VERTICES);
  localparam logic [RadW-1:0] OneInit = RadW'(1) << (RadW - 2);

  back_state_e state_q, state_d;

  logic [CntW-1:0]          n_q, i_q, rd_idx;
  logic                     drop_q, bank_q, deg_q, rd_bank;
  logic signed [CoordW-1:0] rv [3];
  logic signed [CoordW-1:0] pv_q [3];
  logic signed [CoordW-1:0] prev_q [3];
  logic signed [DiffW-1:0]  a_q [3];
  logic signed [DiffW-1:0]  b_q [3];
  logic signed [DiffW-1:0]  d_q [3];
  logic signed [CrossW-1:0] c_q [3];
  logic signed [CrossW-1:0] cm;
  logic [SplitW-2:0]        mh;
  logic [SplitW-1:0]        ml;
  logic signed [MulW-1:0]   mul_a, mul_b;
  logic signed [ProdW-1:0]  p_q;
  logic [RadW-1:0]          acc_q, acc_nx, p_ext, trial;
  logic [RadW-1:0]          op_q, res_q, one_q;
  logic                     sq_area_q;
  logic [2:0]               k_q;
  logic [1:0]               j_q, part_q;
  logic [PerimW-1:0]        perim_q;
  logic [AreaW-1:0]         area_q;
  logic [RootW:0]           psum;
  logic [AreaW:0]           asum;
  logic signed [SumW-1:0]   sum_q [3];
  logic [MagW-1:0]          dvd_q [3];
  logic [CntW-1:0]          rem_q [3];
  logic                     neg_q [3];
  logic [$clog2(MagW)-1:0]  dcnt_q;
  logic                     tri_en, last_v, out_load;
  logic                     out_valid_q;
  result_t                  out_q;
  logic signed [CoordW-1:0] cen [3];

  assign rv[0] = rd_data_i[3*CoordW-1:2*CoordW];
  assign rv[1] = rd_data_i[2*CoordW-1:CoordW];
  assign rv[2] = rd_data_i[CoordW-1:0];

  // a fan triangle closes at every vertex but the first and the last
  assign tri_en = (i_q != '0) && ({1'b0, i_q} + (CntW+1)'(1) < {1'b0, n_q});
  assign last_v = (i_q == n_q - CntW'(1));

  assign cm = c_q[j_q][CrossW-1] ? -c_q[j_q] : c_q[j_q];
  assign mh = cm[2*SplitW-2:SplitW];
  assign ml = cm[SplitW-1:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      BS_PMUL: begin
        mul_a = MulW'(d_q[k_q[1:0]]);
        mul_b = MulW'(d_q[k_q[1:0]]);
      end
      BS_CMUL: begin
        case (k_q)
          3'd0: begin mul_a = MulW'(a_q[1]); mul_b = MulW'(b_q[2]); end
          3'd1: begin mul_a = MulW'(a_q[2]); mul_b = MulW'(b_q[1]); end
          3'd2: begin mul_a = MulW'(a_q[2]); mul_b = MulW'(b_q[0]); end
          3'd3: begin mul_a = MulW'(a_q[0]); mul_b = MulW'(b_q[2]); end
          3'd4: begin mul_a = MulW'(a_q[0]); mul_b = MulW'(b_q[1]); end
          default: begin mul_a = MulW'(a_q[1]); mul_b = MulW'(b_q[0]); end
        endcase
      end
      BS_SMUL: begin
        case (part_q)
          2'd0: begin
            mul_a = $signed({2'b00, mh});
            mul_b = $signed({2'b00, mh});
          end
          2'd1: begin
            mul_a = $signed({2'b00, mh});
            mul_b = $signed({1'b0, ml});
          end
          default: begin
            mul_a = $signed({1'b0, ml});
            mul_b = $signed({1'b0, ml});
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // squares are never negative, so the product goes in unsigned
  assign p_ext = {{(RadW-ProdW+1){1'b0}}, p_q[ProdW-2:0]};
  always_comb begin
    acc_nx = acc_q + p_ext;
    if (state_q == BS_SACC) begin
      case (part_q)
        2'd0:    acc_nx = acc_q + (p_ext << HiShift);
        2'd1:    acc_nx = acc_q + (p_ext << MidShift);
        default: acc_nx = acc_q + p_ext;
      endcase
    end
  end

  assign trial = res_q + one_q;
  assign psum  = (RootW+1)'(perim_q) + (RootW+1)'(res_q[RootW-1:0]);
  assign asum  = (AreaW+1)'(area_q) + (AreaW+1)'(res_q[RootW-1:1]);

  always_comb begin
    state_d   = state_q;
    job_pop_o = 1'b0;
    rd_en_o   = 1'b0;
    rd_idx    = '0;
    release_o = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      BS_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          if (job_i.count < CntW'(MinVertices)) begin
            state_d = BS_OUT;
          end else begin
            rd_en_o = 1'b1;
            rd_idx  = job_i.count - CntW'(1);
            state_d = BS_RDPV;
          end
        end
      end
      BS_RDPV: begin
        rd_en_o = 1'b1;
        state_d = BS_RDV;
      end
      BS_RDV:  state_d = BS_PMUL;
      BS_PMUL: state_d = BS_PACC;
      BS_PACC: state_d = (k_q == 3'd2) ? BS_SQRT : BS_PMUL;
      BS_CMUL: state_d = BS_CACC;
      BS_CACC: state_d = (k_q == 3'd5) ? BS_SMUL : BS_CMUL;
      BS_SMUL: state_d = BS_SACC;
      BS_SACC: state_d = (j_q == 2'd2 && part_q == 2'd2) ? BS_SQRT : BS_SMUL;
      BS_SQRT: begin
        if (one_q == '0) begin
          if (!sq_area_q && tri_en) begin
            state_d = BS_CMUL;
          end else if (last_v) begin
            state_d = BS_DIV;
          end else begin
            rd_en_o = 1'b1;
            rd_idx  = i_q + CntW'(1);
            state_d = BS_RDV;
          end
        end
      end
      BS_DIV: begin
        if (dcnt_q == '1) begin
          state_d = BS_OUT;
        end
      end
      BS_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load  = 1'b1;
          release_o = 1'b1;
          state_d   = BS_IDLE;
        end
      end
      default: state_d = BS_IDLE;
    endcase
  end

  assign rd_bank   = (state_q == BS_IDLE) ? job_i.bank : bank_q;
  assign rd_addr_o = {rd_bank, rd_idx[AddrBits-1:0]};
  assign busy_o    = (state_q != BS_IDLE);

  always_ff @(posedge clk_i) begin
    case (state_q)
      BS_IDLE: begin
        if (job_valid_i) begin
          n_q     <= job_i.count;
          drop_q  <= job_i.dropped;
          bank_q  <= job_i.bank;
          deg_q   <= (job_i.count < CntW'(MinVertices));
          perim_q <= '0;
          area_q  <= '0;
          i_q     <= '0;
          for (int c = 0; c < 3; c++) begin
            sum_q[c] <= '0;
          end
        end
      end
      BS_RDPV: begin
        for (int c = 0; c < 3; c++) begin
          pv_q[c]   <= rv[c];
          prev_q[c] <= rv[c];
        end
      end
      BS_RDV: begin
        for (int c = 0; c < 3; c++) begin
          d_q[c]    <= DiffW'(rv[c]) - DiffW'(prev_q[c]);
          b_q[c]    <= DiffW'(rv[c]) - DiffW'(pv_q[c]);
          a_q[c]    <= DiffW'(prev_q[c]) - DiffW'(pv_q[c]);
          prev_q[c] <= rv[c];
          sum_q[c]  <= sum_q[c] + SumW'(rv[c]);
        end
        acc_q <= '0;
        k_q   <= '0;
      end
      BS_PMUL, BS_CMUL, BS_SMUL: begin
        p_q <= mul_a * mul_b;
      end
      BS_PACC: begin
        acc_q <= acc_nx;
        k_q   <= k_q + 3'd1;
        if (k_q == 3'd2) begin
          op_q      <= acc_nx;
          res_q     <= '0;
          one_q     <= OneInit;
          sq_area_q <= 1'b0;
        end
      end
      BS_CACC: begin
        if (k_q[0]) begin
          c_q[k_q[2:1]] <= c_q[k_q[2:1]] - CrossW'(p_q);
        end else begin
          c_q[k_q[2:1]] <= CrossW'(p_q);
        end
        k_q <= k_q + 3'd1;
        if (k_q == 3'd5) begin
          acc_q  <= '0;
          j_q    <= '0;
          part_q <= '0;
        end
      end
      BS_SACC: begin
        acc_q <= acc_nx;
        if (part_q == 2'd2) begin
          part_q <= '0;
          j_q    <= j_q + 2'd1;
        end else begin
          part_q <= part_q + 2'd1;
        end
        if (j_q == 2'd2 && part_q == 2'd2) begin
          op_q      <= acc_nx;
          res_q     <= '0;
          one_q     <= OneInit;
          sq_area_q <= 1'b1;
        end
      end
      BS_SQRT: begin
        if (one_q != '0) begin
          if (op_q >= trial) begin
            op_q  <= op_q - trial;
            res_q <= (res_q >> 1) + one_q;
          end else begin
            res_q <= res_q >> 1;
          end
          one_q <= one_q >> 2;
        end else begin
          if (sq_area_q) begin
            area_q <= asum[AreaW] ? '1 : asum[AreaW-1:0];
          end else begin
            perim_q <= (psum > (RootW+1)'({PerimW{1'b1}})) ? '1 : psum[PerimW-1:0];
          end
          if (!sq_area_q && tri_en) begin
            k_q <= '0;
          end else if (last_v) begin
            dcnt_q <= '0;
            for (int c = 0; c < 3; c++) begin
              neg_q[c] <= sum_q[c][SumW-1];
              dvd_q[c] <= sum_q[c][SumW-1] ? MagW'(-sum_q[c]) : MagW'(sum_q[c]);
              rem_q[c] <= '0;
            end
          end else begin
            i_q <= i_q + CntW'(1);
          end
        end
      end
      BS_DIV: begin
        dcnt_q <= dcnt_q + 1'b1;
        for (int c = 0; c < 3; c++) begin
          if ({rem_q[c], dvd_q[c][MagW-1]} >= {1'b0, n_q}) begin
            rem_q[c] <= CntW'({rem_q[c], dvd_q[c][MagW-1]} - {1'b0, n_q});
            dvd_q[c] <= {dvd_q[c][MagW-2:0], 1'b1};
          end else begin
            rem_q[c] <= CntW'({rem_q[c], dvd_q[c][MagW-1]});
            dvd_q[c] <= {dvd_q[c][MagW-2:0], 1'b0};
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      cen[c] = neg_q[c] ? -$signed(dvd_q[c][CoordW-1:0]) : $signed(dvd_q[c][CoordW-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.center_x   <= deg_q ? '0 : cen[0];
      out_q.center_y   <= deg_q ? '0 : cen[1];
      out_q.center_z   <= deg_q ? '0 : cen[2];
      out_q.perimeter  <= deg_q ? '0 : perim_q;
      out_q.area       <= deg_q ? '0 : area_q;
      out_q.degenerate <= deg_q;
      out_q.overflow   <= drop_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
endmodule

[sim/testbench.sv]
// self-checking testbench for polygon_area_perimeter_center_3d_unit
// depends on papc3d_pkg and the unit itself; a queue-fed driver, a monitor and a predictor
module testbench;
  import papc3d_pkg::*;

  localparam int unsigned NumVert   = 256;   // store capacity of the unit as instantiated
  localparam int unsigned HoldLen   = 600;   // long receiver hold-off, in cycles
  localparam int unsigned TailWait  = 200;   // extra cycles once nothing is expected

  // one pending vertex transfer plus the idling it is sent with
  typedef struct {
    vertex_t vtx;
    int      tx_idle;   // sender idle chance in percent
    int      rx_idle;   // receiver stall chance from this transfer on
    bit      hold;      // start a long receiver hold-off on acceptance
  } stim_t;

  logic    clk_i;
  logic    rst_ni;
  logic    in_valid_i;
  logic    in_stall_o;
  vertex_t in_data_i;
  logic    out_valid_o;
  logic    out_stall_i;
  result_t out_data_o;

  stim_t   pending_q[$];
  result_t expected_q[$];

  // shadow of the unit's polygon store
  logic signed [CoordW-1:0] shadow_x[NumVert];
  logic signed [CoordW-1:0] shadow_y[NumVert];
  logic signed [CoordW-1:0] shadow_z[NumVert];
  int unsigned shadow_count;
  bit          shadow_dropped;

  int  errors;
  int  vertices_sent;
  int  results_seen;
  int  n_degenerate;
  int  n_overflow;
  int  rx_idle_pct;
  int  hold_left;
  bit  in_taken;
  bit  cur_hold;

  polygon_area_perimeter_center_3d_unit #(.MAX_VERTICES(NumVert)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // floor of the square root of a wide radicand, one bit per step
  function automatic logic [63:0] floor_root(logic [127:0] rad);
    logic [63:0]  root;
    logic [63:0]  cand;
    logic [127:0] sq;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      sq = {64'd0, cand} * {64'd0, cand};
      if (sq <= rad) root = cand;
    end
    return root;
  endfunction

  // euclidean length of a vector, rounded down
  function automatic logic [63:0] vec_length(longint x, longint y, longint z);
    logic [127:0] ax, ay, az;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    az = (z < 0) ? -z : z;
    return floor_root(ax * ax + ay * ay + az * az);
  endfunction

  // store one vertex and, on the closing one, work out the polygon's result
  task automatic predict_polygon(vertex_t v);
    result_t     r;
    longint      sx, sy, sz;
    longint      ax, ay, az, bx, by, bz;
    logic [63:0] perim, area;
    int unsigned n, j, p;
    if (shadow_count < NumVert) begin
      shadow_x[shadow_count] = v.vx;
      shadow_y[shadow_count] = v.vy;
      shadow_z[shadow_count] = v.vz;
      shadow_count++;
    end else begin
      shadow_dropped = 1'b1;
    end
    if (!v.final_vertex) return;
    r = '0;
    n = shadow_count;
    if (n < MinVertices) begin
      // too few vertices: everything zero, flag raised
      r.degenerate = 1'b1;
      n_degenerate++;
    end else begin
      sx = 0; sy = 0; sz = 0;
      perim = 0; area = 0;
      for (int unsigned i = 0; i < n; i++) begin
        sx += shadow_x[i]; sy += shadow_y[i]; sz += shadow_z[i];
        j = (i == 0) ? n - 1 : i - 1;
        perim += vec_length(longint'(shadow_x[i]) - shadow_x[j],
                            longint'(shadow_y[i]) - shadow_y[j],
                            longint'(shadow_z[i]) - shadow_z[j]);
        if (perim > 64'hFFFF_FFFF) perim = 64'hFFFF_FFFF;
      end
      // fan of triangles about the last vertex
      p = n - 1;
      for (int unsigned i = 0; i + 2 < n; i++) begin
        ax = longint'(shadow_x[i])   - shadow_x[p];
        ay = longint'(shadow_y[i])   - shadow_y[p];
        az = longint'(shadow_z[i])   - shadow_z[p];
        bx = longint'(shadow_x[i+1]) - shadow_x[p];
        by = longint'(shadow_y[i+1]) - shadow_y[p];
        bz = longint'(shadow_z[i+1]) - shadow_z[p];
        area += vec_length(ay * bz - az * by, az * bx - ax * bz, ax * by - ay * bx) >> 1;
        if (area > 64'h00FF_FFFF_FFFF_FFFF) area = 64'h00FF_FFFF_FFFF_FFFF;
      end
      r.center_x  = CoordW'(sx / longint'(n));
      r.center_y  = CoordW'(sy / longint'(n));
      r.center_z  = CoordW'(sz / longint'(n));
      r.perimeter = perim[PerimW-1:0];
      r.area      = area[AreaW-1:0];
    end
    r.overflow = shadow_dropped;
    if (shadow_dropped) n_overflow++;
    expected_q.insert(expected_q.size(), r);
    shadow_count   = 0;
    shadow_dropped = 1'b0;
  endtask

  // input side: accept at the rising edge, update the prediction
  always @(posedge clk_i) begin
    in_taken = 1'b0;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      in_taken = 1'b1;
      vertices_sent++;
      predict_polygon(in_data_i);
    end
  end

  // driver: new payload only after the previous transfer went through
  always @(negedge clk_i) begin
    stim_t s;
    logic  drive_valid;
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      if (in_taken && cur_hold) hold_left = HoldLen;
      drive_valid = 1'b0;
      cur_hold = 1'b0;
      if (pending_q.size() > 0) begin
        s = pending_q[0];
        if ($urandom_range(99) >= s.tx_idle) begin
          void'(pending_q.pop_front());
          drive_valid = 1'b1;
          in_data_i   <= s.vtx;
          rx_idle_pct = s.rx_idle;
          cur_hold    = s.hold;
        end
      end
      in_valid_i <= drive_valid;
    end
  end

  // monitor: compare each result transfer against the oldest prediction
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: %p", out_data_o);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_data_o.center_x !== e.center_x) begin
          $error("center_x expected %0d got %0d", e.center_x, out_data_o.center_x); errors++;
        end
        if (out_data_o.center_y !== e.center_y) begin
          $error("center_y expected %0d got %0d", e.center_y, out_data_o.center_y); errors++;
        end
        if (out_data_o.center_z !== e.center_z) begin
          $error("center_z expected %0d got %0d", e.center_z, out_data_o.center_z); errors++;
        end
        if (out_data_o.perimeter !== e.perimeter) begin
          $error("perimeter expected %0d got %0d", e.perimeter, out_data_o.perimeter); errors++;
        end
        if (out_data_o.area !== e.area) begin
          $error("area expected %0d got %0d", e.area, out_data_o.area); errors++;
        end
        if (out_data_o.degenerate !== e.degenerate) begin
          $error("degenerate expected %0b got %0b", e.degenerate, out_data_o.degenerate); errors++;
        end
        if (out_data_o.overflow !== e.overflow) begin
          $error("overflow expected %0b got %0b", e.overflow, out_data_o.overflow); errors++;
        end
      end
    end
  end

  // receiver stall: long hold-off when asked, otherwise random
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // queue one vertex transfer
  task automatic add_vertex(int x, int y, int z, bit last, int txp, int rxp, bit hold = 0);
    stim_t s;
    s.vtx.vx = x[CoordW-1:0];
    s.vtx.vy = y[CoordW-1:0];
    s.vtx.vz = z[CoordW-1:0];
    s.vtx.final_vertex = last;
    s.tx_idle = txp;
    s.rx_idle = rxp;
    s.hold = hold;
    pending_q.insert(pending_q.size(), s);
  endtask

  function automatic int rand_coord();
    if ($urandom_range(3) == 0) return $signed($urandom_range(2047)) - 1024;
    return $signed($urandom_range(20'hFFFFF)) - 524288;
  endfunction

  // a random polygon of the given size under the given idling
  task automatic add_polygon(int size, int txp, int rxp, bit hold = 0);
    for (int i = 0; i < size; i++)
      add_vertex(rand_coord(), rand_coord(), rand_coord(), i == size - 1, txp, rxp,
                 hold && i == 0);
  endtask

  initial begin
    int total, size, ph, txp, rxp;
    int tx_tab[4];
    int rx_tab[4];
    bit held;
    tx_tab = '{0, 69, 0, 21};
    rx_tab = '{0, 0, 69, 21};
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    errors = 0; vertices_sent = 0; results_seen = 0;
    n_degenerate = 0; n_overflow = 0;
    rx_idle_pct = 0; hold_left = 0; in_taken = 1'b0; cur_hold = 1'b0;
    shadow_count = 0; shadow_dropped = 1'b0;
    held = 1'b0;

    // directed: single and double vertex, extremes, flat and zero polygons
    add_vertex(0, 0, 0, 1, 0, 0);
    add_vertex(-524288, 524287, 7, 0, 0, 0);
    add_vertex(524287, -524288, -7, 1, 0, 0);
    add_vertex(524287, 524287, 524287, 0, 0, 0);
    add_vertex(-524288, -524288, -524288, 0, 0, 0);
    add_vertex(524287, -524288, 524287, 1, 0, 0);
    add_vertex(-524288, 524287, -524288, 0, 0, 0);
    add_vertex(524287, 524287, -524288, 0, 0, 0);
    add_vertex(-524288, -524288, 524287, 0, 0, 0);
    add_vertex(524287, -524288, -524288, 1, 0, 0);
    add_vertex(0, 0, 0, 0, 0, 0);
    add_vertex(0, 0, 0, 0, 0, 0);
    add_vertex(0, 0, 0, 1, 0, 0);
    add_vertex(1024, 0, 0, 0, 0, 0);
    add_vertex(2048, 0, 0, 0, 0, 0);
    add_vertex(3072, 0, 0, 1, 0, 0);
    add_vertex(-1, -1, -1, 0, 0, 0);
    add_vertex(-2, 0, 1, 0, 0, 0);
    add_vertex(-3, 1, 0, 1, 0, 0);

    // random polygons over four idling phases, mostly small
    total = 0;
    while (total < 280) begin
      ph = (total * 4) / 280;
      txp = tx_tab[ph];
      rxp = rx_tab[ph];
      case ($urandom_range(9))
        0:       size = $urandom_range(1, 2);
        1:       size = $urandom_range(9, 20);
        default: size = $urandom_range(3, 8);
      endcase
      // long hold-off once in the unthrottled phase so the input backs up
      add_polygon(size, txp, rxp, !held && total > 40);
      if (total > 40) held = 1'b1;
      total += size;
    end
    // full store, then store overflowing with the closing vertex dropped
    add_polygon(NumVert, 21, 21);
    add_polygon(NumVert + 3, 0, 21);
    add_polygon(4, 0, 0);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (pending_q.size() == 0 && !in_valid_i);
    wait (expected_q.size() == 0);
    repeat (TailWait) @(posedge clk_i);

    $display("sent %0d vertices, checked %0d results", vertices_sent, results_seen);
    $display("degenerate polygons %0d, overflowing polygons %0d", n_degenerate, n_overflow);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("[polygon_area_perimeter_center_3d_unit] OK");
    end else begin
      $display("[polygon_area_perimeter_center_3d_unit] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #200000000;
    $display("[polygon_area_perimeter_center_3d_unit] ERROR");
    $finish;
  end

endmodule
